// ----- src/sampq_pkg.sv -----
`timescale 1ns / 1ps

package sampq_pkg;

    // Default depth of the sorted store
    localparam int DEFAULT_CAPACITY = 16;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int OUT_DATA_W = 72;

    // Operation codes
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Command from the controller to the datapath
    typedef struct packed {
        logic load;   // apply one beat this cycle
        logic op;     // operation of that beat
    } sq_cmd_t;

endpackage

// ----- src/sorted_array_min_queue.sv -----
`timescale 1ns / 1ps

// Min-priority queue of signed 32-bit values held in a sorted row of cells.
// Input channel s_*: one beat per operation. s_tuser carries the operation
// (0 insert s_tdata, 1 extract the minimum); s_tdata carries the value.
// Output channel m_*: exactly one beat per input beat, in order. m_tdata
// carries the extracted value, the minimum after the operation, the empty
// flag and the entry count; m_tuser carries the status (0 ok, 1 extract on
// an empty queue, 2 insert dropped because the queue is full).
// The result is registered and is valid in the cycle after the input beat is taken.
// Throughput: one operation per cycle while m_tready stays high; every cell
// compares and shifts in parallel, so the single output register sets the
// pace. While the receiver stalls, the result is held and s_tready drops
// until the output register is taken.
// Reset clears the entry count, so the queue starts empty; the store
// itself needs no clearing since only entries below the count are used.
module sorted_array_min_queue
#(
    parameter int CAPACITY = sampq_pkg::DEFAULT_CAPACITY
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] item_value
    input  logic         s_tuser,   // [0] operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // [31:0] taken_value, [63:32] least_value,
                                    // [64] queue_empty, [69:65] entry_count,
                                    // [71:70] zero
    output logic [1:0]   m_tuser    // [1:0] status
);

    sampq_pkg::sq_cmd_t cmd;
    logic signed [sampq_pkg::VALUE_W-1:0] taken_value;
    logic signed [sampq_pkg::VALUE_W-1:0] least_value;
    logic queue_empty;
    logic [sampq_pkg::COUNT_W-1:0] entry_count;
    logic [sampq_pkg::STATUS_W-1:0] status;

    sampq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    sampq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item_value  (s_tdata),
        .taken_value (taken_value),
        .least_value (least_value),
        .queue_empty (queue_empty),
        .entry_count (entry_count),
        .status      (status)
    );

    // Pack the result beat
    assign m_tdata = {2'b00, entry_count, queue_empty, least_value, taken_value};
    assign m_tuser = status;

endmodule

// ----- src/sampq_ctrl.sv -----
`timescale 1ns / 1ps

module sampq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output sampq_pkg::sq_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // Take a beat when the output register is free or is being emptied
    assign in_ready = (state_reg == ST_IDLE) || out_ready;
    assign accept   = in_valid && in_ready;
    assign out_valid = (state_reg == ST_HOLD);

    assign cmd.load = accept;
    assign cmd.op   = in_op;

    // Track whether a result waits in the output register
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (accept)
                    state_next = ST_HOLD;
                else if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // A stalled result must not be overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.load)
        else $error("beat accepted over a stalled result");

    // Every accepted beat leaves a result waiting
    a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid)
        else $error("accepted beat gave no result");

    // A stalled result stays offered until taken
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("stalled result withdrawn");

endmodule

// ----- src/sampq_datapath.sv -----
`timescale 1ns / 1ps

module sampq_datapath
#(
    parameter int CAPACITY = sampq_pkg::DEFAULT_CAPACITY
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sampq_pkg::sq_cmd_t                cmd,
    input  logic signed [sampq_pkg::VALUE_W-1:0] item_value,
    output logic signed [sampq_pkg::VALUE_W-1:0] taken_value,
    output logic signed [sampq_pkg::VALUE_W-1:0] least_value,
    output logic                              queue_empty,
    output logic [sampq_pkg::COUNT_W-1:0]     entry_count,
    output logic [sampq_pkg::STATUS_W-1:0]    status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic signed [sampq_pkg::VALUE_W-1:0] store_reg  [CAPACITY];
    logic signed [sampq_pkg::VALUE_W-1:0] ins_next   [CAPACITY];
    logic signed [sampq_pkg::VALUE_W-1:0] ext_next   [CAPACITY];
    logic signed [sampq_pkg::VALUE_W-1:0] store_next [CAPACITY];
    logic [CAPACITY-1:0] le;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic is_empty;
    logic is_full;
    logic do_insert;
    logic do_extract;
    logic [sampq_pkg::STATUS_W-1:0] status_next;

    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == CAP_CNT);
    assign do_insert  = cmd.load && (cmd.op == sampq_pkg::OP_INSERT) && !is_full;
    assign do_extract = cmd.load && (cmd.op == sampq_pkg::OP_EXTRACT) && !is_empty;

    // Each cell compares its entry with the new value and picks its next entry
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign le[i] = (CNT_W'(i) < count_reg) && (store_reg[i] <= item_value);

        // Insert: keep when at or before the new value, take it at the boundary,
        // otherwise shift up from the neighbour below
        if (i == 0)
        begin : g_first
            assign ins_next[i] = le[i] ? store_reg[i] : item_value;
        end
        else
        begin : g_rest
            assign ins_next[i] = le[i]     ? store_reg[i]   :
                                 le[i - 1] ? item_value     : store_reg[i - 1];
        end

        // Extract: shift down from the neighbour above
        if (i == CAPACITY - 1)
        begin : g_last
            assign ext_next[i] = store_reg[i];
        end
        else
        begin : g_inner
            assign ext_next[i] = store_reg[i + 1];
        end

        assign store_next[i] = do_insert  ? ins_next[i] :
                               do_extract ? ext_next[i] : store_reg[i];

        // Store entries carry no reset
        always_ff @(posedge clk)
        begin
            if (do_insert || do_extract)
                store_reg[i] <= store_next[i];
        end
    end

    // Work out the new count and status
    always_comb
    begin
        count_next  = count_reg;
        status_next = sampq_pkg::STATUS_OK;
        if (cmd.load)
        begin
            case (cmd.op)
                sampq_pkg::OP_INSERT:
                begin
                    if (is_full)
                        status_next = sampq_pkg::STATUS_FULL;
                    else
                        count_next = count_reg + 1'b1;
                end
                sampq_pkg::OP_EXTRACT:
                begin
                    if (is_empty)
                        status_next = sampq_pkg::STATUS_EMPTY;
                    else
                        count_next = count_reg - 1'b1;
                end
                default:
                    status_next = sampq_pkg::STATUS_OK;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Capture the result of each beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            taken_value <= do_extract ? store_reg[0] : '0;
            least_value <= (count_next != '0) ? store_next[0] : '0;
            queue_empty <= (count_next == '0);
            entry_count <= sampq_pkg::COUNT_W'(count_next);
            status      <= status_next;
        end
    end

    // Count stays within the store
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("fill count beyond capacity");

    // An insert that fits grows the count by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the count");

    // A rejected extract reports the empty status
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.op == sampq_pkg::OP_EXTRACT && is_empty)
        |=> status == sampq_pkg::STATUS_EMPTY)
        else $error("extract on empty not flagged");

    // Valid entries stay in ascending order
    for (genvar i = 0; i < CAPACITY - 1; i++)
    begin : g_order_chk
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            (CNT_W'(i + 1) < count_reg) |-> (store_reg[i] <= store_reg[i + 1]))
            else $error("store out of order");
    end

endmodule

// ----- tb/minq_result_check.sv -----
`timescale 1ns / 1ps

// Watches both channels of the min-queue, keeps its own sorted copy of the
// store, predicts one outcome per accepted operation and compares every
// result beat with the oldest outstanding prediction.
module minq_result_check
#(
    parameter int CAPACITY = sampq_pkg::DEFAULT_CAPACITY
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] item_value
    input  logic         s_tuser,   // [0] operation
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,   // [31:0] taken_value, [63:32] least_value,
                                    // [64] queue_empty, [69:65] entry_count
    input  logic [1:0]   m_tuser,   // [1:0] status
    output int           fail_count,
    output int           pending_count
);

    localparam int OUTCOME_DEPTH = 8;

    typedef struct packed {
        logic [sampq_pkg::VALUE_W-1:0]  taken;
        logic [sampq_pkg::VALUE_W-1:0]  least;
        logic                           empty;
        logic [sampq_pkg::COUNT_W-1:0]  count;
        logic [sampq_pkg::STATUS_W-1:0] status;
    } minq_outcome_t;

    // Shadow of the sorted store, ascending by signed value
    logic signed [sampq_pkg::VALUE_W-1:0] held_values [CAPACITY];
    int                                   held_count = 0;

    // Outstanding predictions, oldest at rd_idx
    minq_outcome_t outcome_fifo [OUTCOME_DEPTH];
    int            rd_idx = 0;
    int            wr_idx = 0;

    // Apply one operation to the shadow store and work out its result beat
    task automatic apply_queue_op(input logic op,
                                  input logic signed [sampq_pkg::VALUE_W-1:0] value,
                                  output minq_outcome_t outcome);
        int pos;
        outcome = '0;
        outcome.status = sampq_pkg::STATUS_OK;
        if (op == sampq_pkg::OP_INSERT)
        begin
            if (held_count >= CAPACITY)
            begin
                outcome.status = sampq_pkg::STATUS_FULL;
            end
            else
            begin
                // go behind every stored entry that is less than or equal
                pos = 0;
                while (pos < held_count && held_values[pos] <= value)
                    pos++;
                for (int i = held_count; i > pos; i--)
                    held_values[i] = held_values[i-1];
                held_values[pos] = value;
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                outcome.status = sampq_pkg::STATUS_EMPTY;
            end
            else
            begin
                outcome.taken = held_values[0];
                for (int i = 1; i < held_count; i++)
                    held_values[i-1] = held_values[i];
                held_count--;
            end
        end
        outcome.least = (held_count > 0) ? held_values[0] : '0;
        outcome.empty = (held_count == 0);
        outcome.count = held_count[sampq_pkg::COUNT_W-1:0];
    endtask

    task automatic compare_field(input string name,
                                 input logic [sampq_pkg::VALUE_W-1:0] want,
                                 input logic [sampq_pkg::VALUE_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        minq_outcome_t want;
        if (rst_n)
        begin
            // Check the result beat first: it always belongs to an earlier operation
            if (m_tvalid && m_tready)
            begin
                if (rd_idx == wr_idx)
                begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = outcome_fifo[rd_idx % OUTCOME_DEPTH];
                    rd_idx++;
                    compare_field("taken_value", want.taken, m_tdata[31:0]);
                    compare_field("least_value", want.least, m_tdata[63:32]);
                    compare_field("queue_empty", 32'(want.empty), 32'(m_tdata[64]));
                    compare_field("entry_count", 32'(want.count), 32'(m_tdata[69:65]));
                    compare_field("status", 32'(want.status), 32'(m_tuser));
                end
            end
            // Predict the outcome of an accepted operation beat
            if (s_tvalid && s_tready)
            begin
                apply_queue_op(s_tuser, s_tdata, want);
                if (wr_idx - rd_idx >= OUTCOME_DEPTH)
                begin
                    $error("too many results outstanding");
                    fail_count++;
                end
                else
                begin
                    outcome_fifo[wr_idx % OUTCOME_DEPTH] = want;
                    wr_idx++;
                end
            end
            pending_count = wr_idx - rd_idx;
        end
    end

endmodule

// ----- tb/sorted_array_min_queue_test.sv -----
`timescale 1ns / 1ps

module sorted_array_min_queue_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 312;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count;
    int pending_count;
    int cycle_count = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sorted_array_min_queue uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    minq_result_check result_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Stall the result channel at the current rate
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Send one operation beat, idling first at the current rate
    task automatic send_op(input logic op, input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Mix extremes, near-zero duplicates and full-width values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return 32'($urandom_range(8)) - 32'd4;
            default: return $urandom();
        endcase
    endfunction

    // Give up on a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[sorted_array_min_queue] ERROR");
        $finish;
    end

    initial
    begin
        int run_len;
        int insert_pct;
        int sent;
        logic op;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= sampq_pkg::OP_INSERT;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extract from an empty queue, then the extremes and a tie at the bottom
        send_op(sampq_pkg::OP_EXTRACT, 32'hFFFF_FFFF);
        send_op(sampq_pkg::OP_INSERT, 32'h7FFF_FFFF);
        send_op(sampq_pkg::OP_INSERT, 32'h8000_0000);
        send_op(sampq_pkg::OP_INSERT, 32'h0000_0000);
        send_op(sampq_pkg::OP_INSERT, 32'hFFFF_FFFF);
        send_op(sampq_pkg::OP_INSERT, 32'h8000_0000);
        send_op(sampq_pkg::OP_EXTRACT, 32'h0000_0000);
        send_op(sampq_pkg::OP_EXTRACT, 32'h5555_5555);

        // Fill to capacity with equal and alternating patterns, then overflow
        for (int i = 0; i < 13; i++)
            send_op(sampq_pkg::OP_INSERT, (i % 3 == 0) ? 32'h0000_0005 :
                    ((i % 2 == 0) ? 32'h5555_5555 : 32'hAAAA_AAAA));
        send_op(sampq_pkg::OP_INSERT, 32'h1234_5678);
        for (int i = 0; i < 3; i++)
            send_op(sampq_pkg::OP_EXTRACT, 32'h0000_0000);

        // Random runs, each leaning toward filling, draining or holding level
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 50;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 50;
                end
                default:
                begin
                    send_idle_pct  = 24;
                    recv_stall_pct = 24;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                run_len = $urandom_range(60, 20);
                case ($urandom_range(2))
                    0:       insert_pct = 15;
                    1:       insert_pct = 50;
                    default: insert_pct = 85;
                endcase
                repeat (run_len)
                begin
                    op = ($urandom_range(99) < insert_pct) ? sampq_pkg::OP_INSERT :
                                                             sampq_pkg::OP_EXTRACT;
                    send_op(op, pick_value());
                end
                sent += run_len;
            end
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("[sorted_array_min_queue] OK");
        else
            $display("[sorted_array_min_queue] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/sampq_pkg.sv
src/sampq_ctrl.sv
src/sampq_datapath.sv
src/sorted_array_min_queue.sv
tb/minq_result_check.sv
tb/sorted_array_min_queue_test.sv
